// File: hw/rtl/fcc_pkg.sv
// ----------------------------------------------------------------------------
// fcc_pkg
// Shared types, constants and the CRC-16/MODBUS byte update for the framed
// packet checker.
// ----------------------------------------------------------------------------
package fcc_pkg;

    // frame layout
    localparam int ID_BYTES         = 16;
    localparam int FAULT_SCAN_BYTES = 16;

    // field counter positions inside the fixed header fields, and the payload scan bound
    localparam logic [7:0] CNT_CMD     = 8'(ID_BYTES);
    localparam logic [7:0] CNT_ADDR_HI = 8'(ID_BYTES + 1);
    localparam logic [7:0] CNT_ADDR_LO = 8'(ID_BYTES + 2);
    localparam logic [7:0] CNT_LEN     = 8'(ID_BYTES + 3);
    localparam logic [7:0] CNT_SCAN    = 8'(FAULT_SCAN_BYTES);

    // crc constants
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // register reset values
    localparam logic [7:0]  HEADER_RESET = 8'hAA;
    localparam logic [15:0] FAULT_RESET  = 16'h0090;

    // noise nibble
    localparam logic [3:0] NOISE_NIBBLE = 4'hF;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // configuration register indexes
    localparam logic CFG_HEADER = 1'b0;
    localparam logic CFG_FAULT  = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_FIELDS,
        PH_PAYLOAD,
        PH_CRC_LO,
        PH_CRC_HI,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_HEADER = 3'd1,
        ST_TRUNCATED = 3'd2,
        ST_CRC_BAD   = 3'd3,
        ST_NOISE     = 3'd4
    } t_status;

    // one classified byte as it travels through the queue
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       last;
        logic       force_fwd;
        logic       hdr_hit;
        logic       noise;
    } t_item;

    // one chunk result
    typedef struct packed {
        t_status     status;
        logic [7:0]  command;
        logic [15:0] frame_address;
        logic        forward;
        logic        fault_frame;
    } t_result;

    // reflected crc-16 update over one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int n = 0; n < 8; n++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/fcc_front.sv
// ----------------------------------------------------------------------------
// fcc_front
// Accepts received bytes, tags header matches and single-byte noise chunks,
// and pushes the tagged bytes into the queue.
// ----------------------------------------------------------------------------
module fcc_front
    import fcc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_last_in_chunk,
    input  logic       i_force_forward,
    input  logic [7:0] i_header_byte,
    input  logic       i_q_full,
    output logic       o_push,
    output t_item      o_item
);

    logic r_first;
    logic n_first;
    logic w_xfer;

    // accept whenever the queue has room
    assign o_stall = i_q_full;
    assign w_xfer  = i_valid && !i_q_full;
    assign o_push  = w_xfer;

    // classify the byte
    always_comb begin
        o_item.rx_byte   = i_rx_byte;
        o_item.last      = i_last_in_chunk;
        o_item.force_fwd = i_force_forward;
        o_item.hdr_hit   = (i_rx_byte == i_header_byte);
        o_item.noise     = r_first && i_last_in_chunk && (i_rx_byte[7:4] == NOISE_NIBBLE);
    end

    // track the first byte of each chunk
    always_comb begin
        n_first = r_first;
        if (w_xfer) begin
            n_first = i_last_in_chunk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else begin
            r_first <= n_first;
        end
    end

endmodule

// File: hw/rtl/fcc_queue.sv
// ----------------------------------------------------------------------------
// fcc_queue
// Small register queue that decouples the byte front end from the parser.
// ----------------------------------------------------------------------------
module fcc_queue
    import fcc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item          r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QAW:0]   r_count;
    logic [QAW-1:0] n_wr_ptr;
    logic [QAW-1:0] n_rd_ptr;
    logic [QAW:0]   n_count;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + QAW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + QAW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + (QAW+1)'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - (QAW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // queue integrity
    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue push while full");
    a_no_underflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue pop while empty");
    a_count_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QAW+1)'(QDEPTH))
        else $error("queue count out of range");

endmodule

// File: hw/rtl/fcc_back.sv
// ----------------------------------------------------------------------------
// fcc_back
// Frame parser: walks the frame fields, runs the CRC, screens the payload
// and registers one result at the end of each chunk.
// ----------------------------------------------------------------------------
module fcc_back
    import fcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_item       i_q_item,
    output logic        o_pop,
    input  logic [15:0] i_fault_address,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_result     o_result
);

    t_phase      r_phase;
    t_phase      n_phase;
    logic [7:0]  r_count;
    logic [7:0]  n_count;
    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic [7:0]  r_cmd;
    logic [7:0]  n_cmd;
    logic [15:0] r_addr;
    logic [15:0] n_addr;
    logic [7:0]  r_len;
    logic [7:0]  n_len;
    logic [7:0]  r_crc_lo;
    logic [7:0]  n_crc_lo;
    logic        r_nonzero;
    logic        n_nonzero;
    logic        r_good;
    logic        n_good;
    logic        r_out_valid;
    t_result     r_result;
    t_result     w_result;
    logic        w_out_free;
    logic        w_is_fault;
    logic [7:0]  w_b;

    assign w_b        = i_q_item.rx_byte;
    assign w_out_free = !r_out_valid || !i_out_stall;
    // a chunk end needs a free result slot
    assign o_pop      = i_q_valid && (!i_q_item.last || w_out_free);

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_HUNT: begin
                if (i_q_item.hdr_hit) begin
                    n_phase = PH_FIELDS;
                end
            end
            PH_FIELDS: begin
                if (r_count == CNT_LEN) begin
                    n_phase = (w_b == 8'd0) ? PH_CRC_LO : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (({1'b0, r_count} + 9'd1) >= {1'b0, r_len}) begin
                    n_phase = PH_CRC_LO;
                end
            end
            PH_CRC_LO: n_phase = PH_CRC_HI;
            PH_CRC_HI: n_phase = PH_DONE;
            PH_DONE:   n_phase = PH_DONE;
            default:   n_phase = PH_HUNT;
        endcase
    end

    // field capture, crc and payload screen
    always_comb begin
        n_count   = r_count;
        n_crc     = r_crc;
        n_cmd     = r_cmd;
        n_addr    = r_addr;
        n_len     = r_len;
        n_crc_lo  = r_crc_lo;
        n_nonzero = r_nonzero;
        n_good    = r_good;
        case (r_phase)
            PH_HUNT: begin
                if (i_q_item.hdr_hit) begin
                    n_crc   = crc16_byte(CRC_INIT, w_b);
                    n_count = 8'd0;
                end
            end
            PH_FIELDS: begin
                n_crc   = crc16_byte(r_crc, w_b);
                n_count = r_count + 8'd1;
                if (r_count == CNT_CMD) begin
                    n_cmd = w_b;
                end else if (r_count == CNT_ADDR_HI) begin
                    n_addr = {w_b, r_addr[7:0]};
                end else if (r_count == CNT_ADDR_LO) begin
                    n_addr = {r_addr[15:8], w_b};
                end else if (r_count == CNT_LEN) begin
                    n_len   = w_b;
                    n_count = 8'd0;
                end
            end
            PH_PAYLOAD: begin
                n_crc   = crc16_byte(r_crc, w_b);
                n_count = r_count + 8'd1;
                if ((r_count < CNT_SCAN) && (w_b != 8'd0)) begin
                    n_nonzero = 1'b1;
                end
            end
            PH_CRC_LO: begin
                n_crc_lo = w_b;
            end
            PH_CRC_HI: begin
                n_good = ({w_b, r_crc_lo} == r_crc);
            end
            default: begin
            end
        endcase
    end

    // chunk result from the state after this byte
    always_comb begin
        w_is_fault = (n_addr == i_fault_address);
        w_result   = '0;
        if (i_q_item.noise) begin
            w_result.status = ST_NOISE;
        end else if (n_phase == PH_HUNT) begin
            w_result.status = ST_NO_HEADER;
        end else if (n_phase != PH_DONE) begin
            w_result.status = ST_TRUNCATED;
        end else if (!n_good) begin
            w_result.status = ST_CRC_BAD;
        end else begin
            w_result.status        = ST_OK;
            w_result.command       = n_cmd;
            w_result.frame_address = n_addr;
            w_result.forward       = i_q_item.force_fwd || !w_is_fault || n_nonzero;
            w_result.fault_frame   = w_is_fault;
        end
    end

    // parser control state, cleared at each chunk end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_nonzero <= 1'b0;
        end else if (o_pop) begin
            if (i_q_item.last) begin
                r_phase   <= PH_HUNT;
                r_nonzero <= 1'b0;
            end else begin
                r_phase   <= n_phase;
                r_nonzero <= n_nonzero;
            end
        end
    end

    // parser datapath
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_count  <= n_count;
            r_crc    <= n_crc;
            r_cmd    <= n_cmd;
            r_addr   <= n_addr;
            r_len    <= n_len;
            r_crc_lo <= n_crc_lo;
            r_good   <= n_good;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_q_item.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_q_item.last) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    // parser checks
    a_chunk_restart : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_q_item.last) |=> (r_phase == PH_HUNT && !r_nonzero))
        else $error("parser not restarted after chunk end");
    a_no_result_overrun : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_q_item.last) |-> w_out_free)
        else $error("result overwritten while held");
    a_crc_hi_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && !i_q_item.last && r_phase == PH_CRC_LO) |=> (r_phase == PH_CRC_HI))
        else $error("crc high byte phase skipped");

endmodule

// File: hw/rtl/framed_packet_crc16_checker.sv
// ----------------------------------------------------------------------------
// framed_packet_crc16_checker
// Checks one received chunk per result: finds the header, parses the frame,
// verifies CRC-16/MODBUS and reports status and forward decision.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; a held result stops the parser at the next
// chunk end, and the input stalls once the four-entry queue is full.
// The last byte of a chunk passes through a queue entry and then the result
// register before the chunk's result is valid.
// Reset (synchronous, active low): empties the queue and result register,
// parser hunts for a header, header byte 0xAA, fault address 0x0090.
module framed_packet_crc16_checker
    import fcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_last_in_chunk,
    input  logic        i_force_forward,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [7:0]  o_command,
    output logic [15:0] o_frame_address,
    output logic        o_forward,
    output logic        o_fault_frame,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [7:0]  r_header_byte;
    logic [15:0] r_fault_address;
    logic        w_q_full;
    logic        w_push;
    t_item       w_push_item;
    logic        w_pop;
    logic        w_q_valid;
    t_item       w_q_item;
    t_result     w_result;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_byte   <= HEADER_RESET;
            r_fault_address <= FAULT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HEADER: r_header_byte   <= i_cfg_data[7:0];
                CFG_FAULT:  r_fault_address <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // byte front end
    fcc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in_valid),
        .o_stall         (o_in_stall),
        .i_rx_byte       (i_rx_byte),
        .i_last_in_chunk (i_last_in_chunk),
        .i_force_forward (i_force_forward),
        .i_header_byte   (r_header_byte),
        .i_q_full        (w_q_full),
        .o_push          (w_push),
        .o_item          (w_push_item)
    );

    // decoupling queue
    fcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    // frame parser and result register
    fcc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_q_item        (w_q_item),
        .o_pop           (w_pop),
        .i_fault_address (r_fault_address),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_result        (w_result)
    );

    // result fields
    assign o_status        = w_result.status;
    assign o_command       = w_result.command;
    assign o_frame_address = w_result.frame_address;
    assign o_forward       = w_result.forward;
    assign o_fault_frame   = w_result.fault_frame;

endmodule
